// ===== sv/mrpl_pkg.sv =====
// Shared types and constants for the mesh replay protection list.
// No dependencies; used by every module and the checker.
package mrpl_pkg;

    localparam int CMD_W       = 2;
    localparam int VERDICT_W   = 2;
    localparam int ADDR_W      = 16;
    localparam int EPOCH_W     = 32;
    localparam int SEQ_IN_W    = 32;
    localparam int SRC_W       = 15;
    localparam int SEQ_W       = 24;
    localparam int COUNT_W     = 32;
    localparam int LIST_SIZE_W = 6;
    localparam int S_DATA_W    = ADDR_W + EPOCH_W + SEQ_IN_W;

    localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_REPLAY = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_REJECT = 2'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_NONE   = 2'd3;

    localparam logic [ADDR_W-1:0]      SRC_MIN         = 16'h0001;
    localparam logic [ADDR_W-1:0]      SRC_MAX         = 16'h7fff;
    localparam logic [SEQ_IN_W-1:0]    SEQ_MAX         = 32'h00ff_ffff;
    localparam logic [LIST_SIZE_W-1:0] LIST_SIZE_RESET = 6'd32;

    // One table record as stored in the entry memory.
    typedef struct packed {
        logic               valid;
        logic [SRC_W-1:0]   source;
        logic [EPOCH_W-1:0] epoch;
        logic [SEQ_W-1:0]   seq_num;
    } entry_t;

    // Per-entry classification from the shared compare unit.
    typedef struct packed {
        logic free;
        logic match;
        logic newer;
        logic stale;
    } eval_t;

endpackage

// ===== sv/mesh_replay_protection_list_unit.sv =====
// Top level of the mesh replay protection list: request sequencer and drop counter.
// Depends on mrpl_pkg, mrpl_ram and mrpl_eval.

// Replay protection list for mesh network packets. Each request on the slave
// stream (command in tuser, source/IV/sequence in tdata) yields exactly one
// result on the master stream (verdict in tuser, drop counter in tdata). The
// table lives in a single-port-read memory and is walked one entry per cycle
// by a shared compare unit, so a peek or check scans list_size_in_use entries
// (stopping early when the source is found); invalid, disabled and
// unused-command requests skip the scan. A clear walks all ENTRIES records.
// After reset the same clearing pass runs with s_axis_tready low; cfg writes
// are taken during it. The block holds one request at a time; a finished
// result sits in the output register so the next request can be taken while
// the sink stalls. The user must write list_size only while the block is
// idle; the block itself does not enforce it. Values above ENTRIES act as
// ENTRIES, zero rejects every peek and check.
module mesh_replay_protection_list_unit #(
    parameter int ENTRIES = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] source_address, [47:16] iv_epoch, [79:48] sequence_number
    input  logic [mrpl_pkg::S_DATA_W-1:0]       s_axis_tdata,
    // [1:0] command
    input  logic [mrpl_pkg::CMD_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] drop_count
    output logic [mrpl_pkg::COUNT_W-1:0]        m_axis_tdata,
    // [1:0] verdict
    output logic [mrpl_pkg::VERDICT_W-1:0]      m_axis_tuser,
    input  logic                                cfg_wr_en,
    input  logic [mrpl_pkg::LIST_SIZE_W-1:0]    cfg_wr_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int SZ_W  = (CNT_W > mrpl_pkg::LIST_SIZE_W) ? CNT_W : mrpl_pkg::LIST_SIZE_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CLEAR  = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    // control state
    state_t                                 state_reg, state_next;
    logic [mrpl_pkg::LIST_SIZE_W-1:0]       list_size_reg, list_size_next;
    logic [mrpl_pkg::COUNT_W-1:0]           drop_reg, drop_next;
    logic [IDX_W-1:0]                       clear_cnt_reg, clear_cnt_next;
    logic                                   clear_out_reg, clear_out_next;
    logic                                   out_valid_reg, out_valid_next;

    // request and scan payload
    logic [mrpl_pkg::CMD_W-1:0]             req_cmd_reg, req_cmd_next;
    logic [mrpl_pkg::SRC_W-1:0]             req_src_reg, req_src_next;
    logic [mrpl_pkg::EPOCH_W-1:0]           req_iv_reg, req_iv_next;
    logic [mrpl_pkg::SEQ_W-1:0]             req_seq_reg, req_seq_next;
    logic [IDX_W-1:0]                       ev_idx_reg, ev_idx_next;
    logic                                   free_found_reg, free_found_next;
    logic [IDX_W-1:0]                       free_idx_reg, free_idx_next;
    logic                                   stale_found_reg, stale_found_next;
    logic [IDX_W-1:0]                       stale_idx_reg, stale_idx_next;
    logic [IDX_W-1:0]                       where_reg, where_next;
    logic                                   commit_reg, commit_next;
    logic [mrpl_pkg::VERDICT_W-1:0]         verdict_reg, verdict_next;
    logic [mrpl_pkg::VERDICT_W-1:0]         out_verdict_reg, out_verdict_next;
    logic [mrpl_pkg::COUNT_W-1:0]           out_drop_reg, out_drop_next;

    // incoming fields
    logic [mrpl_pkg::ADDR_W-1:0]            in_src;
    logic [mrpl_pkg::EPOCH_W-1:0]           in_iv;
    logic [mrpl_pkg::SEQ_IN_W-1:0]          in_seq;
    logic [mrpl_pkg::CMD_W-1:0]             in_cmd;
    logic                                   in_ok;

    logic [SZ_W-1:0]                        list_ext;
    logic [SZ_W-1:0]                        eff_size;
    logic [SZ_W-1:0]                        idx_plus1;
    logic                                   scan_last;
    logic                                   clear_last;
    logic                                   is_check;

    logic                                   ram_wr_en;
    logic [IDX_W-1:0]                       ram_wr_addr;
    mrpl_pkg::entry_t                       ram_wr_data;
    logic                                   ram_rd_en;
    logic [IDX_W-1:0]                       ram_rd_addr;
    mrpl_pkg::entry_t                       ram_rd_data;
    mrpl_pkg::entry_t                       new_entry;
    mrpl_pkg::eval_t                        ev;

    logic                                   free_any, stale_any;
    logic [IDX_W-1:0]                       free_pick, stale_pick;

    assign in_src = s_axis_tdata[15:0];
    assign in_iv  = s_axis_tdata[47:16];
    assign in_seq = s_axis_tdata[79:48];
    assign in_cmd = s_axis_tuser;

    // size in use saturates at the table depth
    assign list_ext  = SZ_W'(list_size_reg);
    assign eff_size  = (list_ext > SZ_W'(ENTRIES)) ? SZ_W'(ENTRIES) : list_ext;
    assign in_ok     = (in_src >= mrpl_pkg::SRC_MIN) && (in_src <= mrpl_pkg::SRC_MAX) &&
                       (in_seq <= mrpl_pkg::SEQ_MAX) && (eff_size != '0);
    assign idx_plus1  = SZ_W'(ev_idx_reg) + SZ_W'(1);
    assign scan_last  = (idx_plus1 == eff_size);
    assign clear_last = (clear_cnt_reg == IDX_W'(ENTRIES - 1));
    assign is_check   = (req_cmd_reg == mrpl_pkg::CMD_CHECK);

    assign new_entry.valid   = 1'b1;
    assign new_entry.source  = req_src_reg;
    assign new_entry.epoch   = req_iv_reg;
    assign new_entry.seq_num = req_seq_reg;

    mrpl_ram #(
        .DEPTH (ENTRIES),
        .IDX_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    mrpl_eval u_eval (
        .entry      (ram_rd_data),
        .req_source (req_src_reg),
        .req_epoch  (req_iv_reg),
        .req_seq    (req_seq_reg),
        .result     (ev)
    );

    // first free and first stale slot seen so far, including this entry
    assign free_any   = free_found_reg || ev.free;
    assign free_pick  = free_found_reg ? free_idx_reg : ev_idx_reg;
    assign stale_any  = stale_found_reg || ev.stale;
    assign stale_pick = stale_found_reg ? stale_idx_reg : ev_idx_reg;

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        list_size_next   = cfg_wr_en ? cfg_wr_data : list_size_reg;
        drop_next        = drop_reg;
        clear_cnt_next   = clear_cnt_reg;
        clear_out_next   = clear_out_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        req_cmd_next     = req_cmd_reg;
        req_src_next     = req_src_reg;
        req_iv_next      = req_iv_reg;
        req_seq_next     = req_seq_reg;
        ev_idx_next      = ev_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        stale_found_next = stale_found_reg;
        stale_idx_next   = stale_idx_reg;
        where_next       = where_reg;
        commit_next      = commit_reg;
        verdict_next     = verdict_reg;
        out_verdict_next = out_verdict_reg;
        out_drop_next    = out_drop_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = where_reg;
        ram_wr_data      = new_entry;
        ram_rd_en        = 1'b0;
        ram_rd_addr      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    req_cmd_next = in_cmd;
                    req_src_next = in_src[mrpl_pkg::SRC_W-1:0];
                    req_iv_next  = in_iv;
                    req_seq_next = in_seq[mrpl_pkg::SEQ_W-1:0];
                    commit_next  = 1'b0;
                    case (in_cmd)
                        mrpl_pkg::CMD_CLEAR:
                        begin
                            clear_cnt_next = '0;
                            clear_out_next = 1'b1;
                            state_next     = ST_CLEAR;
                        end
                        mrpl_pkg::CMD_PEEK, mrpl_pkg::CMD_CHECK:
                        begin
                            if (in_ok)
                            begin
                                // entry 0 is read now, evaluated next cycle
                                ram_rd_en        = 1'b1;
                                ram_rd_addr      = '0;
                                ev_idx_next      = '0;
                                free_found_next  = 1'b0;
                                stale_found_next = 1'b0;
                                state_next       = ST_SCAN;
                            end
                            else
                            begin
                                verdict_next = mrpl_pkg::VERDICT_REJECT;
                                state_next   = ST_FINISH;
                            end
                        end
                        default:
                        begin
                            verdict_next = mrpl_pkg::VERDICT_REJECT;
                            state_next   = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_CLEAR:
            begin
                ram_wr_en      = 1'b1;
                ram_wr_addr    = clear_cnt_reg;
                ram_wr_data    = '0;
                clear_cnt_next = clear_cnt_reg + IDX_W'(1);
                if (clear_last)
                begin
                    drop_next   = '0;
                    commit_next = 1'b0;
                    if (clear_out_reg)
                    begin
                        verdict_next = mrpl_pkg::VERDICT_ACCEPT;
                        state_next   = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_SCAN:
            begin
                if (ev.match)
                begin
                    verdict_next = ev.newer ? mrpl_pkg::VERDICT_ACCEPT : mrpl_pkg::VERDICT_REPLAY;
                    where_next   = ev_idx_reg;
                    commit_next  = is_check && ev.newer;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    free_found_next  = free_any;
                    free_idx_next    = free_pick;
                    stale_found_next = stale_any;
                    stale_idx_next   = stale_pick;
                    if (scan_last)
                    begin
                        state_next = ST_FINISH;
                        if (free_any)
                        begin
                            verdict_next = mrpl_pkg::VERDICT_ACCEPT;
                            where_next   = free_pick;
                            commit_next  = is_check;
                        end
                        else if (stale_any)
                        begin
                            verdict_next = mrpl_pkg::VERDICT_ACCEPT;
                            where_next   = stale_pick;
                            commit_next  = is_check;
                        end
                        else
                        begin
                            // table full: counted for peek and check alike
                            verdict_next = mrpl_pkg::VERDICT_REJECT;
                            commit_next  = 1'b0;
                            drop_next    = drop_reg + mrpl_pkg::COUNT_W'(1);
                        end
                    end
                    else
                    begin
                        ev_idx_next = ev_idx_reg + IDX_W'(1);
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = ev_idx_reg + IDX_W'(1);
                    end
                end
            end

            ST_FINISH:
            begin
                // write repeats harmlessly while the output register is busy
                ram_wr_en = commit_reg;
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_verdict_next = verdict_reg;
                    out_drop_next    = drop_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            list_size_reg <= mrpl_pkg::LIST_SIZE_RESET;
            drop_reg      <= '0;
            clear_cnt_reg <= '0;
            clear_out_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            list_size_reg <= list_size_next;
            drop_reg      <= drop_next;
            clear_cnt_reg <= clear_cnt_next;
            clear_out_reg <= clear_out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_cmd_reg     <= req_cmd_next;
        req_src_reg     <= req_src_next;
        req_iv_reg      <= req_iv_next;
        req_seq_reg     <= req_seq_next;
        ev_idx_reg      <= ev_idx_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        stale_found_reg <= stale_found_next;
        stale_idx_reg   <= stale_idx_next;
        where_reg       <= where_next;
        commit_reg      <= commit_next;
        verdict_reg     <= verdict_next;
        out_verdict_reg <= out_verdict_next;
        out_drop_reg    <= out_drop_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_drop_reg;
    assign m_axis_tuser  = out_verdict_reg;

endmodule

// ===== sv/mrpl_ram.sv =====
// Entry memory of the replay list: one write port, one registered read port.
// Depends on mrpl_pkg (entry_t).
module mrpl_ram #(
    parameter int DEPTH = 32,
    parameter int IDX_W = 5
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  mrpl_pkg::entry_t      wr_data,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_addr,
    output mrpl_pkg::entry_t      rd_data
);

    mrpl_pkg::entry_t mem [DEPTH];
    mrpl_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/mrpl_eval.sv =====
// Shared compare unit: classifies one stored record against the request.
// Depends on mrpl_pkg (entry_t, eval_t).
module mrpl_eval (
    input  mrpl_pkg::entry_t                  entry,
    input  logic [mrpl_pkg::SRC_W-1:0]        req_source,
    input  logic [mrpl_pkg::EPOCH_W-1:0]      req_epoch,
    input  logic [mrpl_pkg::SEQ_W-1:0]        req_seq,
    output mrpl_pkg::eval_t                   result
);

    logic [mrpl_pkg::EPOCH_W:0] epoch_plus1;

    // 33-bit sum so a record at the top IV never wraps into looking stale
    assign epoch_plus1 = {1'b0, entry.epoch} + {{mrpl_pkg::EPOCH_W{1'b0}}, 1'b1};

    always_comb
    begin
        result.free  = !entry.valid;
        result.match = entry.valid && (entry.source == req_source);
        if (req_epoch != entry.epoch)
        begin
            result.newer = req_epoch > entry.epoch;
        end
        else
        begin
            result.newer = req_seq > entry.seq_num;
        end
        result.stale = entry.valid && (epoch_plus1 < {1'b0, req_epoch});
    end

endmodule

// ===== sv/mrpl_checker.sv =====
// Port-level checker for the mesh replay protection list, bound to the top level.
// Depends on mrpl_pkg and mesh_replay_protection_list_unit.
module mrpl_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [mrpl_pkg::COUNT_W-1:0]        m_axis_tdata,
    input logic [mrpl_pkg::VERDICT_W-1:0]      m_axis_tuser
);

    logic       in_xfer, out_xfer;
    logic [1:0] pending_reg, pending_next;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    // requests taken whose result has not been transferred yet
    always_comb
    begin
        pending_next = pending_reg;
        if (in_xfer && !out_xfer)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (!in_xfer && out_xfer)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !s_axis_tready)
        else $error("slave side ready right after a request transfer");

    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (pending_reg != 2'd0))
        else $error("result offered with no request outstanding");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (pending_reg == 2'd0 || pending_reg == 2'd1))
        else $error("ready while a request is still being worked");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser != mrpl_pkg::VERDICT_NONE))
        else $error("result carries an undefined verdict");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind mesh_replay_protection_list_unit mrpl_checker u_mrpl_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for mesh_replay_protection_list_unit.
// Needs mrpl_pkg and the unit RTL. It uses a directed table and then random
// traffic, and checks each result against a built-in replay-list predictor or a hand-computed outcome.
module testbench;

    import mrpl_pkg::*;

    localparam int TABLE_DEPTH      = 32;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 2 * TABLE_DEPTH;
    localparam int PROBE_ROWS       = 30;

    // Expected contents of one master-side transfer.
    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic [COUNT_W-1:0]   drops;
    } rpl_outcome_t;

    // Directed row: either a list_size write or one request, with an
    // optional hand-computed outcome.
    typedef struct packed {
        logic                   cfg_row;
        logic [LIST_SIZE_W-1:0] size;
        logic [CMD_W-1:0]       cmd;
        logic [ADDR_W-1:0]      src;
        logic [EPOCH_W-1:0]     iv;
        logic [SEQ_IN_W-1:0]    seq;
        logic                   typed;
        logic [VERDICT_W-1:0]   verdict;
        logic [COUNT_W-1:0]     drops;
    } probe_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_DATA_W-1:0]    s_axis_tdata;
    logic [CMD_W-1:0]       s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [COUNT_W-1:0]     m_axis_tdata;
    logic [VERDICT_W-1:0]   m_axis_tuser;
    logic                   cfg_wr_en;
    logic [LIST_SIZE_W-1:0] cfg_wr_data;

    // Predictor copy of the table, counter and size register.
    logic                   rpl_valid [TABLE_DEPTH];
    logic [SRC_W-1:0]       rpl_source [TABLE_DEPTH];
    logic [EPOCH_W-1:0]     rpl_epoch [TABLE_DEPTH];
    logic [SEQ_W-1:0]       rpl_seq [TABLE_DEPTH];
    logic [COUNT_W-1:0]     rpl_drops;
    logic [LIST_SIZE_W-1:0] rpl_size;

    rpl_outcome_t outcome_queue [$];
    int           mismatches = 0;
    int           cycle_count;
    bit           steady_flow = 1'b0;
    bit           hold_request = 1'b0;

    probe_row_t probe_table [0:PROBE_ROWS-1] = '{
        // empty table, peek finds a free slot
        '{1'b0, 6'd0, CMD_PEEK,   16'h0001, 32'h0,         32'h0,         1'b1, VERDICT_ACCEPT, 32'd0},
        // invalid source and sequence values
        '{1'b0, 6'd0, CMD_CHECK,  16'h0000, 32'h0,         32'h0,         1'b1, VERDICT_REJECT, 32'd0},
        '{1'b0, 6'd0, CMD_CHECK,  16'hffff, 32'hffffffff, 32'hffffffff, 1'b1, VERDICT_REJECT, 32'd0},
        '{1'b0, 6'd0, CMD_CHECK,  16'h0005, 32'h0,         32'h01000000, 1'b1, VERDICT_REJECT, 32'd0},
        // unused command is rejected and changes nothing
        '{1'b0, 6'd0, CMD_UNUSED, 16'h0005, 32'h1,         32'h1,         1'b1, VERDICT_REJECT, 32'd0},
        // top source, top IV, top sequence
        '{1'b0, 6'd0, CMD_CHECK,  16'h7fff, 32'hffffffff, 32'h00ffffff, 1'b1, VERDICT_ACCEPT, 32'd0},
        '{1'b0, 6'd0, CMD_CHECK,  16'h7fff, 32'hffffffff, 32'h00ffffff, 1'b1, VERDICT_REPLAY, 32'd0},
        '{1'b0, 6'd0, CMD_PEEK,   16'h7fff, 32'hffffffff, 32'h00fffffe, 1'b1, VERDICT_REPLAY, 32'd0},
        // newer sequence, then newer IV with lower sequence
        '{1'b0, 6'd0, CMD_CHECK,  16'h0001, 32'h0,         32'h0,         1'b1, VERDICT_ACCEPT, 32'd0},
        '{1'b0, 6'd0, CMD_CHECK,  16'h0001, 32'h0,         32'h0,         1'b1, VERDICT_REPLAY, 32'd0},
        '{1'b0, 6'd0, CMD_CHECK,  16'h0001, 32'h0,         32'h1,         1'b1, VERDICT_ACCEPT, 32'd0},
        '{1'b0, 6'd0, CMD_CHECK,  16'h0001, 32'h1,         32'h0,         1'b1, VERDICT_ACCEPT, 32'd0},
        '{1'b0, 6'd0, CMD_CLEAR,  16'h0000, 32'h0,         32'h0,         1'b1, VERDICT_ACCEPT, 32'd0},
        // two-entry list: fill it, then full drops and stale reclaim
        '{1'b1, 6'd2, CMD_PEEK,   16'h0000, 32'h0,         32'h0,         1'b0, VERDICT_ACCEPT, 32'd0},
        '{1'b0, 6'd0, CMD_CHECK,  16'h0010, 32'h5,         32'h0,         1'b1, VERDICT_ACCEPT, 32'd0},
        '{1'b0, 6'd0, CMD_CHECK,  16'h0011, 32'hffffffff, 32'h0,         1'b1, VERDICT_ACCEPT, 32'd0},
        '{1'b0, 6'd0, CMD_CHECK,  16'h0012, 32'h6,         32'h0,         1'b1, VERDICT_REJECT, 32'd1},
        '{1'b0, 6'd0, CMD_PEEK,   16'h0012, 32'h7,         32'h0,         1'b1, VERDICT_ACCEPT, 32'd1},
        '{1'b0, 6'd0, CMD_PEEK,   16'h0013, 32'h6,         32'h0,         1'b1, VERDICT_REJECT, 32'd2},
        '{1'b0, 6'd0, CMD_CHECK,  16'h0012, 32'h7,         32'h3,         1'b1, VERDICT_ACCEPT, 32'd2},
        '{1'b0, 6'd0, CMD_CHECK,  16'h0010, 32'h5,         32'h1,         1'b1, VERDICT_REJECT, 32'd3},
        // disabled list rejects without counting
        '{1'b1, 6'd0, CMD_PEEK,   16'h0000, 32'h0,         32'h0,         1'b0, VERDICT_ACCEPT, 32'd0},
        '{1'b0, 6'd0, CMD_CHECK,  16'h0012, 32'h8,         32'h4,         1'b1, VERDICT_REJECT, 32'd3},
        // oversize setting acts as the full table
        '{1'b1, 6'd63, CMD_PEEK,  16'h0000, 32'h0,         32'h0,         1'b0, VERDICT_ACCEPT, 32'd0},
        '{1'b0, 6'd0, CMD_CHECK,  16'h0020, 32'h0,         32'h0,         1'b0, VERDICT_ACCEPT, 32'd0},
        '{1'b0, 6'd0, CMD_CHECK,  16'h0011, 32'hffffffff, 32'h00ffffff, 1'b0, VERDICT_ACCEPT, 32'd0},
        // shrink hides entry 1, grow brings it back intact
        '{1'b1, 6'd1, CMD_PEEK,   16'h0000, 32'h0,         32'h0,         1'b0, VERDICT_ACCEPT, 32'd0},
        '{1'b0, 6'd0, CMD_CHECK,  16'h0011, 32'h0,         32'h0,         1'b1, VERDICT_REJECT, 32'd4},
        '{1'b1, 6'd32, CMD_PEEK,  16'h0000, 32'h0,         32'h0,         1'b0, VERDICT_ACCEPT, 32'd0},
        '{1'b0, 6'd0, CMD_CHECK,  16'h0011, 32'hffffffff, 32'h00ffffff, 1'b1, VERDICT_REPLAY, 32'd4}
    };

    mesh_replay_protection_list_unit #(
        .ENTRIES(TABLE_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void rpl_wipe();
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            rpl_valid[i]  = 1'b0;
            rpl_source[i] = '0;
            rpl_epoch[i]  = '0;
            rpl_seq[i]    = '0;
        end
        rpl_drops = '0;
    endfunction

    // Classify one request and commit it to the predictor table.
    function automatic rpl_outcome_t rpl_classify(input logic [CMD_W-1:0] cmd,
                                                  input logic [ADDR_W-1:0] src,
                                                  input logic [EPOCH_W-1:0] iv,
                                                  input logic [SEQ_IN_W-1:0] seq);
        rpl_outcome_t res;
        int           span;
        int           pick;
        int           slot;
        logic         found;
        logic         newer;
        span  = (rpl_size > TABLE_DEPTH) ? TABLE_DEPTH : int'(rpl_size);
        pick  = -1;
        slot  = -1;
        found = 1'b0;
        res.verdict = VERDICT_ACCEPT;
        if (cmd == CMD_CLEAR)
            rpl_wipe();
        else if (cmd == CMD_UNUSED)
            res.verdict = VERDICT_REJECT;
        else if (span == 0 || src < SRC_MIN || src > SRC_MAX || seq > SEQ_MAX)
            res.verdict = VERDICT_REJECT;
        else
        begin
            for (int i = 0; i < span && !found; i++)
            begin
                if (!rpl_valid[i])
                begin
                    if (pick < 0)
                        pick = i;
                end
                else if (rpl_source[i] == src[SRC_W-1:0])
                begin
                    found = 1'b1;
                    newer = (iv != rpl_epoch[i]) ? (iv > rpl_epoch[i])
                                                 : (seq[SEQ_W-1:0] > rpl_seq[i]);
                    if (newer)
                        slot = i;
                    else
                        res.verdict = VERDICT_REPLAY;
                end
            end
            if (!found)
            begin
                // no free slot: reclaim the first record two or more IVs behind
                if (pick < 0)
                begin
                    for (int i = 0; i < span && pick < 0; i++)
                        if (rpl_valid[i] && ({1'b0, rpl_epoch[i]} + 33'd1 < {1'b0, iv}))
                            pick = i;
                end
                if (pick < 0)
                begin
                    rpl_drops   = rpl_drops + 1;
                    res.verdict = VERDICT_REJECT;
                end
                else
                    slot = pick;
            end
            if (cmd == CMD_CHECK && res.verdict == VERDICT_ACCEPT && slot >= 0)
            begin
                rpl_valid[slot]  = 1'b1;
                rpl_source[slot] = src[SRC_W-1:0];
                rpl_epoch[slot]  = iv;
                rpl_seq[slot]    = seq[SEQ_W-1:0];
            end
        end
        res.drops = rpl_drops;
        return res;
    endfunction

    // Entered and left at a falling edge.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] src,
                                input logic [EPOCH_W-1:0] iv, input logic [SEQ_IN_W-1:0] seq,
                                input logic typed, input logic [VERDICT_W-1:0] verdict,
                                input logic [COUNT_W-1:0] drops);
        rpl_outcome_t want;
        while (!steady_flow && $urandom_range(0, 99) < 25)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {seq, iv, src};
        do
            @(posedge clk);
        while (!s_axis_tready);
        want = rpl_classify(cmd, src, iv, seq);
        if (typed)
        begin
            want.verdict = verdict;
            want.drops   = drops;
        end
        outcome_queue.push_back(want);
        @(negedge clk);
    endtask

    // Only while idle: every expected transfer has come back.
    task automatic write_list_size(input logic [LIST_SIZE_W-1:0] size);
        s_axis_tvalid <= 1'b0;
        while (outcome_queue.size() != 0)
            @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size;
        rpl_size = size;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Random traffic from a small pool of sources, a few more than the slots,
    // so that matches, replays, full drops and stale reclaims all occur.
    task automatic run_traffic(input logic [LIST_SIZE_W-1:0] size, input int count,
                               input bit squeeze);
        int                  span;
        int                  r;
        logic [ADDR_W-1:0]   pool_base;
        logic [EPOCH_W-1:0]  iv_floor;
        logic [CMD_W-1:0]    cmd;
        logic [ADDR_W-1:0]   src;
        logic [EPOCH_W-1:0]  iv;
        logic [SEQ_IN_W-1:0] seq;
        write_list_size(size);
        if (squeeze)
        begin
            steady_flow  = 1'b1;
            hold_request = 1'b1;
        end
        span      = ((size > TABLE_DEPTH) ? TABLE_DEPTH : int'(size)) + 3;
        pool_base = 16'($urandom_range(1, 16'h7fff - 40));
        iv_floor  = ($urandom_range(0, 3) == 0) ? 32'hffff_fff0 : $urandom;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                cmd = CMD_CHECK;
            else if (r < 97)
                cmd = CMD_PEEK;
            else if (r < 98)
                cmd = CMD_CLEAR;
            else
                cmd = CMD_UNUSED;

            r = $urandom_range(0, 99);
            if (r < 90)
                src = pool_base + 16'($urandom_range(0, span - 1));
            else if (r < 95)
                src = ($urandom_range(0, 1) == 0) ? 16'h0000 : (16'h8000 | 16'($urandom));
            else
                src = 16'($urandom);

            if ($urandom_range(0, 15) == 0)
                iv_floor = iv_floor + $urandom_range(1, 2);
            r = $urandom_range(0, 9);
            if (r < 8)
                iv = iv_floor + $urandom_range(0, 1);
            else if (r == 8)
                iv = iv_floor - $urandom_range(1, 2);
            else
                iv = $urandom;

            r = $urandom_range(0, 99);
            if (r < 85)
                seq = $urandom_range(0, 63);
            else if (r < 90)
                seq = SEQ_MAX - $urandom_range(0, 3);
            else if (r < 95)
                seq = $urandom_range(32'h0100_0000, 32'hffff_ffff);
            else
                seq = $urandom & SEQ_MAX;

            send_request(cmd, src, iv, seq, 1'b0, VERDICT_ACCEPT, '0);
        end
        steady_flow = 1'b0;
    endtask

    // Result sink: random back-pressure, plus one long hold on request.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                for (int held = 0; held < SINK_HOLD_CYCLES; held++)
                    @(negedge clk);
            end
            m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= 25);
        end
    end

    // Result checker: each transfer against the oldest expectation.
    always @(posedge clk)
    begin
        rpl_outcome_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (outcome_queue.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, actual verdict %0d drop_count %0d",
                         $time, m_axis_tuser, m_axis_tdata);
            end
            else
            begin
                want = outcome_queue.pop_front();
                if (m_axis_tuser !== want.verdict)
                begin
                    mismatches++;
                    $display("%0t: verdict expected %0d actual %0d",
                             $time, want.verdict, m_axis_tuser);
                end
                if (m_axis_tdata !== want.drops)
                begin
                    mismatches++;
                    $display("%0t: drop_count expected %0d actual %0d",
                             $time, want.drops, m_axis_tdata);
                end
            end
        end
    end

    // Watchdog.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("mesh_replay_protection_list_unit test failed");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_PEEK;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        rpl_wipe();
        rpl_size = LIST_SIZE_RESET;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < PROBE_ROWS; i++)
        begin
            if (probe_table[i].cfg_row)
                write_list_size(probe_table[i].size);
            else
                send_request(probe_table[i].cmd, probe_table[i].src, probe_table[i].iv,
                             probe_table[i].seq, probe_table[i].typed,
                             probe_table[i].verdict, probe_table[i].drops);
        end

        run_traffic(6'd32, 140, 1'b0);
        run_traffic(6'd1, 80, 1'b0);
        run_traffic(6'd2, 80, 1'b0);
        // no idling on either side, one long sink hold to back up the input
        run_traffic(6'd8, 100, 1'b1);
        run_traffic(6'd0, 30, 1'b0);
        run_traffic(6'd63, 140, 1'b0);
        run_traffic(6'd33, 80, 1'b0);
        run_traffic(6'($urandom_range(3, 31)), 100, 1'b0);

        s_axis_tvalid <= 1'b0;
        while (outcome_queue.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("mesh_replay_protection_list_unit test passed");
        else
            $display("mesh_replay_protection_list_unit test failed");
        $finish;
    end

endmodule
